>>> design/bcld_pkg.sv
`default_nettype none
package bcld_pkg;

   localparam int LANES       = 4;
   localparam int NUM_BUTTONS = 4;

   localparam int DEB_W  = 8;
   localparam int HOLD_W = 16;
   localparam int WIN_W  = 16;
   localparam int IDX_W  = 2;
   localparam int DATA_W = 16;

   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd3;
   localparam logic [HOLD_W-1:0] LONG_RESET     = 16'd100;
   localparam logic [WIN_W-1:0]  WINDOW_RESET   = 16'd20;

   typedef enum logic [IDX_W-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_LONG     = 2'd1,
      CSR_WINDOW   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_RELEASED = 2'd0,
      PH_PRESSED  = 2'd1,
      PH_WAITING  = 2'd2,
      PH_SECOND   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

   typedef struct packed {
      logic [DEB_W-1:0]  debounce_ticks;
      logic [HOLD_W-1:0] long_press_ticks;
      logic [WIN_W-1:0]  double_window_ticks;
   } cfg_type;

endpackage
`default_nettype wire

>>> design/bcld_req_if.sv
`default_nettype none
interface bcld_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] pressed_mask;

   modport source (output valid, output pressed_mask, input ready);
   modport sink   (input valid, input pressed_mask, output ready);
endinterface
`default_nettype wire

>>> design/bcld_rsp_if.sv
`default_nettype none
interface bcld_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_button0;
   logic [1:0] event_button1;
   logic [1:0] event_button2;
   logic [1:0] event_button3;

   modport source (output valid, output event_button0, output event_button1,
                   output event_button2, output event_button3, input ready);
   modport sink   (input valid, input event_button0, input event_button1,
                   input event_button2, input event_button3, output ready);
endinterface
`default_nettype wire

>>> design/bcld_csr_if.sv
`default_nettype none
interface bcld_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/button_click_long_double_detector_core.sv
// Click / long-press / double-click detector for four buttons.
// req_ch: one transfer per scan tick, pressed_mask bit i high while button i
//    is held. rsp_ch: one transfer per tick with a 2-bit event per button
//    (none, click, long, double). csr_ch: writes to debounce_ticks (0),
//    long_press_ticks (1), double_window_ticks (2); other indexes are
//    dropped. csr_ch is always ready; write only while no tick is in flight.
// Each button has its own lane that updates its phase and counters in the
// cycle a tick is taken; the lane outputs are registered in one output stage.
// The result of a tick shows on rsp_ch in the cycle after the tick transfer.
// Throughput: one tick per cycle while rsp_ch takes each result, limited by the single output register.
// When rsp_ch stalls, the held result stays put and req_ch.ready drops until
// it is taken; req_ch.ready stays high while the result is consumed in the
// same cycle.
// Reset: all lanes go to released with cleared counters, thresholds return to
// 3 / 100 / 20 and no result is pending. No clearing pass is needed.
`default_nettype none
module button_click_long_double_detector_core
   import bcld_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   bcld_req_if.sink   req_ch,
   bcld_rsp_if.source rsp_ch,
   bcld_csr_if.sink   csr_ch
);

   cfg_type               cfg_ff, cfg_in;
   logic                  tick;
   logic                  in_ready;
   logic                  csr_fire;
   event_type [LANES-1:0] lane_event;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         case (csr_ch.index)
            CSR_DEBOUNCE: cfg_in.debounce_ticks      = csr_ch.data[DEB_W-1:0];
            CSR_LONG:     cfg_in.long_press_ticks    = csr_ch.data[HOLD_W-1:0];
            CSR_WINDOW:   cfg_in.double_window_ticks = csr_ch.data[WIN_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks      <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks    <= LONG_RESET;
         cfg_ff.double_window_ticks <= WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ch.ready = in_ready;
   assign tick         = req_ch.valid && in_ready;

   for (genvar b = 0; b < LANES; b++) begin : g_lane
      if (b < NUM_BUTTONS) begin : g_used
         bcld_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .tick      (tick),
            .down      (req_ch.pressed_mask[b]),
            .cfg       (cfg_ff),
            .event_out (lane_event[b])
         );
      end else begin : g_unused
         assign lane_event[b] = EV_NONE;
      end
   end

   bcld_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .lane_event (lane_event),
      .in_ready   (in_ready),
      .rsp        (rsp_ch)
   );

   a_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      tick |=> rsp_ch.valid)
      else $error("accepted tick produced no result");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input accepted while result stalled");

   a_debounce_write: assert property (@(posedge clock) disable iff (reset)
      (csr_ch.valid && csr_ch.index == CSR_DEBOUNCE)
      |=> cfg_ff.debounce_ticks == $past(csr_ch.data[DEB_W-1:0]))
      else $error("debounce threshold write lost");

   a_long_write: assert property (@(posedge clock) disable iff (reset)
      (csr_ch.valid && csr_ch.index == CSR_LONG)
      |=> cfg_ff.long_press_ticks == $past(csr_ch.data))
      else $error("long-press threshold write lost");

endmodule
`default_nettype wire

>>> design/bcld_lane.sv
`default_nettype none
module bcld_lane
   import bcld_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      tick,
   input  wire logic      down,
   input  wire cfg_type   cfg,
   output event_type      event_out
);

   phase_type         phase_ff, phase_in;
   logic [DEB_W-1:0]  deb_ff, deb_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic              lock_ff, lock_in;

   logic [DEB_W-1:0]  deb_inc;
   logic [HOLD_W-1:0] hold_inc;
   logic [WIN_W-1:0]  win_inc;
   logic              deb_done, hold_done, win_done;

   // counters bump first, then compare against threshold
   assign deb_inc   = deb_ff + DEB_W'(1);
   assign hold_inc  = hold_ff + HOLD_W'(1);
   assign win_inc   = win_ff + WIN_W'(1);
   assign deb_done  = deb_inc >= cfg.debounce_ticks;
   assign hold_done = hold_inc >= cfg.long_press_ticks;
   assign win_done  = win_inc >= cfg.double_window_ticks;

   always_comb begin
      phase_in = phase_ff;
      deb_in   = deb_ff;
      hold_in  = hold_ff;
      win_in   = win_ff;
      lock_in  = lock_ff;
      case (phase_ff)
         PH_RELEASED: begin
            if (down) begin
               if (!lock_ff) begin
                  deb_in = deb_done ? '0 : deb_inc;
                  if (deb_done) begin
                     phase_in = PH_PRESSED;
                     hold_in  = '0;
                  end
               end else begin
                  deb_in = '0;
               end
            end else begin
               deb_in  = '0;
               lock_in = 1'b0;
            end
         end
         PH_PRESSED, PH_SECOND: begin
            if (down) begin
               hold_in = hold_done ? '0 : hold_inc;
               if (hold_done) begin
                  phase_in = PH_RELEASED;
                  lock_in  = 1'b1;
               end
            end else begin
               deb_in = deb_done ? '0 : deb_inc;
               if (deb_done) begin
                  if (phase_ff == PH_SECOND) begin
                     phase_in = PH_RELEASED;
                     lock_in  = 1'b0;
                  end else if (!lock_ff) begin
                     phase_in = PH_WAITING;
                     win_in   = '0;
                  end else begin
                     phase_in = PH_RELEASED;
                  end
               end
            end
         end
         PH_WAITING: begin
            if (down) begin
               deb_in = deb_done ? '0 : deb_inc;
               if (deb_done) begin
                  phase_in = PH_SECOND;
                  hold_in  = '0;
               end
            end else begin
               win_in = win_done ? '0 : win_inc;
               if (win_done) begin
                  phase_in = PH_RELEASED;
               end
            end
         end
         default: begin
            phase_in = PH_RELEASED;
         end
      endcase
   end

   always_comb begin
      event_out = EV_NONE;
      case (phase_ff)
         PH_PRESSED: begin
            if (down && hold_done) event_out = EV_LONG;
         end
         PH_SECOND: begin
            if (down && hold_done) event_out = EV_LONG;
            else if (!down && deb_done) event_out = EV_DOUBLE;
         end
         PH_WAITING: begin
            if (!down && win_done) event_out = EV_CLICK;
         end
         default: begin
            event_out = EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASED;
         deb_ff   <= '0;
         hold_ff  <= '0;
         win_ff   <= '0;
         lock_ff  <= 1'b0;
      end else if (tick) begin
         phase_ff <= phase_in;
         deb_ff   <= deb_in;
         hold_ff  <= hold_in;
         win_ff   <= win_in;
         lock_ff  <= lock_in;
      end
   end

endmodule
`default_nettype wire

>>> design/bcld_merge.sv
`default_nettype none
module bcld_merge
   import bcld_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              tick,
   input  wire event_type [LANES-1:0] lane_event,
   output logic                   in_ready,
   bcld_rsp_if.source             rsp
);

   logic                  valid_ff, valid_in;
   event_type [LANES-1:0] ev_ff;

   // output register frees up in the same cycle it is taken
   assign in_ready = !valid_ff || rsp.ready;
   assign valid_in = tick || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         ev_ff <= lane_event;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.event_button0 = ev_ff[0];
   assign rsp.event_button1 = ev_ff[1];
   assign rsp.event_button2 = ev_ff[2];
   assign rsp.event_button3 = ev_ff[3];

endmodule
`default_nettype wire

>>> dv/testbench.sv
module testbench;
   import bcld_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [IDX_W-1:0] CSR_SPARE = 2'd3;  // unmapped index, writes dropped
   localparam int HOLD_OFF_CYCLES = 48;
   localparam int HOLD_OFF_AT = 100;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_RUN = 400;

   typedef logic [LANES-1:0][1:0] lane_events_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcld_req_if req_ch ();
   bcld_rsp_if rsp_ch ();
   bcld_csr_if csr_ch ();

   button_click_long_double_detector_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // button model state and thresholds
   cfg_type     thresholds;
   phase_type   lane_phase [LANES];
   logic [7:0]  lane_debounce [LANES];
   logic [15:0] lane_hold [LANES];
   logic [15:0] lane_window [LANES];
   logic        lane_lockout [LANES];

   logic [3:0]      scan_ticks [$];
   lane_events_type expected_events [$];

   int unsigned idle_pct = 31;
   int          mismatches = 0;
   int          results_seen = 0;
   int          hold_off_left = 0;
   int          quiet_cycles = 0;

   // stimulus shaping: current level and remaining run length per button
   logic [3:0] held_level = '0;
   int         run_left [LANES] = '{default: 0};

   logic [3:0] directed_masks [22] = '{
      4'h0, 4'hF, 4'h0, 4'h0, 4'h0,
      4'hF, 4'hF, 4'hF, 4'hF, 4'hF,
      4'hF, 4'h0,
      4'hF, 4'h0, 4'hF, 4'h0,
      4'h1, 4'h2, 4'h4, 4'h8, 4'h0, 4'hF
   };

   function automatic logic debounce_hit(int b);
      lane_debounce[b] = lane_debounce[b] + 8'd1;
      if (lane_debounce[b] >= thresholds.debounce_ticks) begin
         lane_debounce[b] = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic hold_hit(int b);
      lane_hold[b] = lane_hold[b] + 16'd1;
      if (lane_hold[b] >= thresholds.long_press_ticks) begin
         lane_hold[b] = '0;
         lane_phase[b] = PH_RELEASED;
         lane_lockout[b] = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic event_type lane_update(int b, logic down);
      case (lane_phase[b])
         PH_RELEASED: begin
            if (down) begin
               if (!lane_lockout[b]) begin
                  if (debounce_hit(b)) begin
                     lane_phase[b] = PH_PRESSED;
                     lane_hold[b] = '0;
                     lane_lockout[b] = 1'b0;
                  end
               end else begin
                  lane_debounce[b] = '0;
               end
            end else begin
               lane_debounce[b] = '0;
               lane_lockout[b] = 1'b0;
            end
         end
         PH_PRESSED: begin
            if (down) begin
               if (hold_hit(b)) return EV_LONG;
            end else if (debounce_hit(b)) begin
               if (!lane_lockout[b]) begin
                  lane_phase[b] = PH_WAITING;
                  lane_window[b] = '0;
               end else begin
                  lane_phase[b] = PH_RELEASED;
               end
            end
         end
         PH_WAITING: begin
            if (down) begin
               if (debounce_hit(b)) begin
                  lane_phase[b] = PH_SECOND;
                  lane_hold[b] = '0;
               end
            end else begin
               lane_window[b] = lane_window[b] + 16'd1;
               if (lane_window[b] >= thresholds.double_window_ticks) begin
                  lane_phase[b] = PH_RELEASED;
                  lane_window[b] = '0;
                  return EV_CLICK;
               end
            end
         end
         default: begin
            if (down) begin
               if (hold_hit(b)) return EV_LONG;
            end else if (debounce_hit(b)) begin
               lane_phase[b] = PH_RELEASED;
               lane_lockout[b] = 1'b0;
               return EV_DOUBLE;
            end
         end
      endcase
      return EV_NONE;
   endfunction

   function automatic lane_events_type scan_tick_events(logic [3:0] mask);
      lane_events_type evs;
      evs = '0;
      for (int b = 0; b < LANES; b++)
         if (b < NUM_BUTTONS) evs[b] = lane_update(b, mask[b]);
      return evs;
   endfunction

   // run length of the next level: glitches, short presses, long holds,
   // gaps inside and past the double-click window
   function automatic int pick_run(logic pressed);
      int deb, hold, win, r, len;
      deb  = (thresholds.debounce_ticks == 0) ? 1 : int'(thresholds.debounce_ticks);
      hold = (thresholds.long_press_ticks == 0) ? 1 : int'(thresholds.long_press_ticks);
      win  = (thresholds.double_window_ticks == 0) ? 1 : int'(thresholds.double_window_ticks);
      if (hold > MAX_RUN) hold = MAX_RUN;
      if (win > MAX_RUN) win = MAX_RUN;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         len = $urandom_range(1, deb);
      end else if (pressed) begin
         if (r < 60) len = deb + $urandom_range(0, 2);
         else if (r < 85) len = deb + hold + $urandom_range(0, 3);
         else len = $urandom_range(1, deb + hold + 4);
      end else begin
         if (r < 55) len = deb + $urandom_range(0, win - 1);
         else if (r < 85) len = deb + win + $urandom_range(0, 3);
         else len = $urandom_range(1, deb + win + 4);
      end
      if (len > MAX_RUN) len = MAX_RUN;
      return len;
   endfunction

   task automatic queue_ticks(int count);
      logic [3:0] mask;
      @(negedge clock);
      repeat (count) begin
         for (int b = 0; b < LANES; b++) begin
            if (run_left[b] == 0) begin
               held_level[b] = !held_level[b];
               run_left[b] = pick_run(held_level[b]);
            end
            run_left[b]--;
         end
         mask = held_level;
         if ($urandom_range(0, 99) < 10) mask ^= 4'(1 << $urandom_range(0, 3));
         scan_ticks.push_back(mask);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (scan_ticks.size() != 0 || req_ch.valid || expected_events.size() != 0);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock);
      while (!csr_ch.ready);
      case (idx)
         CSR_DEBOUNCE: thresholds.debounce_ticks = value[DEB_W-1:0];
         CSR_LONG:     thresholds.long_press_ticks = value;
         CSR_WINDOW:   thresholds.double_window_ticks = value;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_phase(logic [15:0] deb, logic [15:0] hold, logic [15:0] win,
                            int count, int unsigned pct);
      wait_drained();
      idle_pct = pct;
      write_csr(CSR_DEBOUNCE, deb);
      write_csr(CSR_LONG, hold);
      write_csr(CSR_WINDOW, win);
      queue_ticks(count);
   endtask

   // tick driver; the model advances on each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_events.push_back(scan_tick_events(req_ch.pressed_mask));
         if (!req_ch.valid || req_ch.ready) begin
            if (scan_ticks.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.pressed_mask <= scan_ticks.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
               req_ch.pressed_mask <= 4'($urandom);
            end
         end
      end
   end

   // event monitor
   always @(posedge clock) begin
      lane_events_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.event_button3, rsp_ch.event_button2,
                   rsp_ch.event_button1, rsp_ch.event_button0};
            if (expected_events.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
               want = expected_events.pop_front();
               for (int b = 0; b < LANES; b++)
                  if (got[b] !== want[b]) begin
                     mismatches++;
                     $display("%0t: button %0d event expected %0d, actual %0d",
                              $time, b, want[b], got[b]);
                  end
            end
            results_seen++;
            // one long receiver stall so the output stage backs up into req_ch
            if (results_seen == HOLD_OFF_AT) hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.pressed_mask = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      thresholds = '{DEBOUNCE_RESET, LONG_RESET, WINDOW_RESET};
      for (int b = 0; b < LANES; b++) begin
         lane_phase[b] = PH_RELEASED;
         lane_debounce[b] = '0;
         lane_hold[b] = '0;
         lane_window[b] = '0;
         lane_lockout[b] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // short thresholds so click, long press, lockout and double show quickly
      write_csr(CSR_DEBOUNCE, 16'd1);
      write_csr(CSR_LONG, 16'd4);
      write_csr(CSR_WINDOW, 16'd2);
      @(negedge clock);
      foreach (directed_masks[i]) scan_ticks.push_back(directed_masks[i]);

      run_phase(16'd2, 16'd10, 16'd5, 140, 31);
      run_phase(16'd1, 16'd1, 16'd1, 80, 31);
      run_phase(16'd0, 16'd0, 16'd0, 60, 31);     // zero thresholds behave as one
      run_phase(16'd3, 16'd100, 16'd20, 220, 0);  // back-to-back, no idling
      run_phase(16'd255, 16'hFFFF, 16'hFFFF, 60, 31);
      run_phase(16'd5, 16'd16, 16'd9, 150, 31);

      // dropped index, then upper data bits above the 8-bit debounce field
      wait_drained();
      write_csr(CSR_SPARE, 16'hFFFF);
      run_phase(16'hA502, 16'd6, 16'd3, 80, 31);

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> button_click_long_double_detector_core.f
design/bcld_pkg.sv
design/bcld_req_if.sv
design/bcld_rsp_if.sv
design/bcld_csr_if.sv
design/bcld_lane.sv
design/bcld_merge.sv
design/button_click_long_double_detector_core.sv
dv/testbench.sv
